[src/mau_pkg.sv]
// Shared types and constants for the modular arithmetic unit.
// No dependencies; imported by modular_arith_unit_core.
`timescale 1ns / 1ps

package mau_pkg;

    // default operand width
    localparam int DEF_WIDTH = 32;

    // fixed field widths
    localparam int FUNC_W = 2;
    localparam int MOD_W  = 31;
    localparam int RES_TDATA_W = 32;

    // signed width of the Euclid coefficients and of quotient*coefficient
    localparam int COEF_W = MOD_W + 3;

    // operation codes carried in s_tuser
    typedef enum logic [FUNC_W-1:0] {
        FN_ADD = 2'd0,
        FN_SUB = 2'd1,
        FN_MUL = 2'd2,
        FN_INV = 2'd3
    } func_t;

endpackage

[src/modular_arith_unit_core.sv]
// Modular add / subtract / multiply / inverse unit with a bit-serial divider.
// Depends on mau_pkg.
`timescale 1ns / 1ps
//
// Channel | Dir | Payload
// --------+-----+-----------------------------------------------------------
// s_      | in  | tuser: func; tdata: operand_a, operand_b, modulus
// m_      | out | tdata: result; tuser: no_inverse
//
// One beat at a time; s_tready is high only while the sequencer is idle.
// The restoring divider takes one quotient bit per cycle. The sequencer
// passes through idle after each result before the next beat is taken. A
// finished result waits in the output register while the next beat is
// taken. Reset (aresetn low, synchronous) returns to idle and drops any
// pending result.

module modular_arith_unit_core #(
    parameter int WIDTH = mau_pkg::DEF_WIDTH,
    localparam int SDW = ((2 * WIDTH + mau_pkg::MOD_W + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [SDW-1:0]                    s_tdata,   // operand_a, operand_b, modulus
    input  logic [mau_pkg::FUNC_W-1:0]        s_tuser,   // func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mau_pkg::RES_TDATA_W-1:0]   m_tdata,   // result
    output logic                              m_tuser    // no_inverse
);
    import mau_pkg::*;

    localparam int DW    = (WIDTH > 32) ? WIDTH : 32;
    localparam int CNT_W = $clog2(DW + 1);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_RED_A   = 11'b000_0000_0010,
        S_FIX_A   = 11'b000_0000_0100,
        S_RED_B   = 11'b000_0000_1000,
        S_FIX_B   = 11'b000_0001_0000,
        S_ARITH   = 11'b000_0010_0000,
        S_MUL     = 11'b000_0100_0000,
        S_INV_CHK = 11'b000_1000_0000,
        S_INV_DIV = 11'b001_0000_0000,
        S_INV_UPD = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } state_t;

    state_t                     state_reg, state_next;
    func_t                      func_reg, func_next;
    logic [WIDTH-1:0]           a_reg, a_next;
    logic [WIDTH-1:0]           b_reg, b_next;
    logic [MOD_W-1:0]           m_reg, m_next;
    logic [MOD_W-1:0]           ra_reg, ra_next;
    logic [MOD_W-1:0]           rb_reg, rb_next;
    logic [DW-1:0]              num_reg, num_next;
    logic [MOD_W-1:0]           md_reg, md_next;
    logic signed [COEF_W-1:0]   c1_reg, c1_next;
    logic signed [COEF_W-1:0]   c2_reg, c2_next;
    logic signed [COEF_W-1:0]   prod_reg, prod_next;
    logic [DW-1:0]              dq_reg, dq_next;
    logic [MOD_W-1:0]           drem_reg, drem_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [MOD_W:0]             acc_reg, acc_next;
    logic                       phase_reg, phase_next;
    logic [MOD_W-1:0]           res_reg, res_next;
    logic                       flag_reg, flag_next;
    logic                       out_valid_reg, out_valid_next;
    logic [MOD_W-1:0]           out_res_reg, out_res_next;
    logic                       out_flag_reg, out_flag_next;

    // divider step
    logic [MOD_W-1:0]           div_d;
    logic [MOD_W:0]             div_t, div_diff;
    logic                       div_ge;
    logic [MOD_W-1:0]           div_rem_step;
    logic                       div_last;

    // operand magnitudes and residue fix-up
    logic [WIDTH-1:0]           b_mag;
    logic [MOD_W-1:0]           fix_res;
    logic                       fix_neg;

    // shared modular helpers
    logic [MOD_W:0]             sum_ab, dbl, mul_sum;
    logic signed [COEF_W-1:0]   c2_fix;
    logic                       inv_flag;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg};
    assign m_tuser  = out_flag_reg;

    always_comb begin
        b_mag = b_reg[WIDTH-1] ? (~b_reg + WIDTH'(1)) : b_reg;
    end

    // one restoring division step: shift in the next dividend bit
    always_comb begin
        div_d        = (state_reg == S_INV_DIV) ? md_reg : m_reg;
        div_t        = {drem_reg, dq_reg[DW-1]};
        div_diff     = div_t - {1'b0, div_d};
        div_ge       = (div_t >= {1'b0, div_d});
        div_rem_step = div_ge ? div_diff[MOD_W-1:0] : div_t[MOD_W-1:0];
        div_last     = (cnt_reg == CNT_W'(DW - 1));
    end

    // floor residue from remainder of the magnitude
    always_comb begin
        fix_neg = (state_reg == S_FIX_A) ? a_reg[WIDTH-1] : b_reg[WIDTH-1];
        fix_res = (fix_neg && (drem_reg != '0)) ? (m_reg - drem_reg) : drem_reg;
    end

    always_comb begin
        sum_ab   = {1'b0, ra_reg} + {1'b0, rb_reg};
        dbl      = {acc_reg[MOD_W-1:0], 1'b0};
        mul_sum  = acc_reg + (rb_reg[MOD_W-1] ? {1'b0, ra_reg} : '0);
        c2_fix   = (c2_reg < 0) ? (c2_reg + COEF_W'(m_reg)) : c2_reg;
        inv_flag = ((num_reg == '0) && (m_reg != MOD_W'(1))) || (num_reg > DW'(1));
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        m_next         = m_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        num_next       = num_reg;
        md_next        = md_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        prod_next      = prod_reg;
        dq_next        = dq_reg;
        drem_next      = drem_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        phase_next     = phase_reg;
        res_next       = res_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_flag_next  = out_flag_reg;

        // drop the result once taken
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    func_next = func_t'(s_tuser);
                    a_next    = s_tdata[WIDTH-1:0];
                    b_next    = s_tdata[2*WIDTH-1:WIDTH];
                    m_next    = s_tdata[2*WIDTH+MOD_W-1:2*WIDTH];
                    if (s_tdata[2*WIDTH+MOD_W-1:2*WIDTH] == '0) begin
                        res_next   = '0;
                        flag_next  = (func_t'(s_tuser) == FN_INV);
                        state_next = S_DONE;
                    end else begin
                        dq_next    = DW'(s_tdata[WIDTH-1] ?
                                         (~s_tdata[WIDTH-1:0] + WIDTH'(1)) :
                                         s_tdata[WIDTH-1:0]);
                        drem_next  = '0;
                        cnt_next   = '0;
                        state_next = S_RED_A;
                    end
                end
            end
            S_RED_A, S_RED_B: begin
                drem_next = div_rem_step;
                dq_next   = {dq_reg[DW-2:0], div_ge};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (div_last) begin
                    state_next = (state_reg == S_RED_A) ? S_FIX_A : S_FIX_B;
                end
            end
            S_FIX_A: begin
                ra_next = fix_res;
                if (func_reg == FN_INV) begin
                    num_next   = a_reg[WIDTH-1] ? DW'(fix_res) : DW'(a_reg);
                    md_next    = m_reg;
                    c1_next    = '0;
                    c2_next    = COEF_W'(1);
                    state_next = S_INV_CHK;
                end else begin
                    dq_next    = DW'(b_mag);
                    drem_next  = '0;
                    cnt_next   = '0;
                    state_next = S_RED_B;
                end
            end
            S_FIX_B: begin
                rb_next    = fix_res;
                acc_next   = '0;
                phase_next = 1'b0;
                cnt_next   = '0;
                state_next = (func_reg == FN_MUL) ? S_MUL : S_ARITH;
            end
            S_ARITH: begin
                flag_next = 1'b0;
                if (func_reg == FN_ADD) begin
                    res_next = (sum_ab >= {1'b0, m_reg}) ?
                               MOD_W'(sum_ab - {1'b0, m_reg}) : MOD_W'(sum_ab);
                end else begin
                    res_next = (ra_reg >= rb_reg) ? (ra_reg - rb_reg) :
                               (ra_reg + m_reg - rb_reg);
                end
                state_next = S_DONE;
            end
            S_MUL: begin
                // double, then add the multiplicand when the bit is set
                if (!phase_reg) begin
                    acc_next   = (dbl >= {1'b0, m_reg}) ? (dbl - {1'b0, m_reg}) : dbl;
                    phase_next = 1'b1;
                end else begin
                    acc_next   = (mul_sum >= {1'b0, m_reg}) ?
                                 (mul_sum - {1'b0, m_reg}) : mul_sum;
                    rb_next    = {rb_reg[MOD_W-2:0], 1'b0};
                    phase_next = 1'b0;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(MOD_W - 1)) begin
                        res_next   = (mul_sum >= {1'b0, m_reg}) ?
                                     MOD_W'(mul_sum - {1'b0, m_reg}) : MOD_W'(mul_sum);
                        flag_next  = 1'b0;
                        state_next = S_DONE;
                    end
                end
            end
            S_INV_CHK: begin
                if ((num_reg > DW'(1)) && (md_reg != '0)) begin
                    dq_next    = num_reg;
                    drem_next  = '0;
                    prod_next  = '0;
                    cnt_next   = '0;
                    state_next = S_INV_DIV;
                end else begin
                    flag_next  = inv_flag;
                    res_next   = inv_flag ? '0 : c2_fix[MOD_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_INV_DIV: begin
                // accumulate quotient times c1 as quotient bits appear
                drem_next = div_rem_step;
                dq_next   = {dq_reg[DW-2:0], div_ge};
                prod_next = (prod_reg <<< 1) + (div_ge ? c1_reg : '0);
                cnt_next  = cnt_reg + CNT_W'(1);
                if (div_last) begin
                    state_next = S_INV_UPD;
                end
            end
            S_INV_UPD: begin
                num_next   = DW'(md_reg);
                md_next    = drem_reg;
                c1_next    = c2_reg - prod_reg;
                c2_next    = c1_reg;
                state_next = S_INV_CHK;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_flag_next  = flag_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        m_reg        <= m_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        num_reg      <= num_next;
        md_reg       <= md_next;
        c1_reg       <= c1_next;
        c2_reg       <= c2_next;
        prod_reg     <= prod_next;
        dq_reg       <= dq_next;
        drem_reg     <= drem_next;
        cnt_reg      <= cnt_next;
        acc_reg      <= acc_next;
        phase_reg    <= phase_next;
        res_reg      <= res_next;
        flag_reg     <= flag_next;
        out_res_reg  <= out_res_next;
        out_flag_reg <= out_flag_next;
    end

endmodule
